### hdl/kvt_pkg.sv
// Package for the key-value table: sizes, status codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package kvt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 32;

  // Port widths, fixed by the interface.
  localparam int REQ_KEY_BITS = 32;
  localparam int REQ_VAL_BITS = 32;
  localparam int STATUS_BITS  = 3;
  localparam int ENTRY_BITS   = 8;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [STATUS_BITS-1:0] ST_UPDATED   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef struct packed {
    logic                   load;     // capture a request, restart the scan
    logic                   scan;     // issue the next key read
    logic                   wr_key;   // append a key at the fill count
    logic                   wr_val;   // write the value store
    logic                   at_hit;   // value access goes to the matched slot
    logic                   respond;  // register a result word
    logic                   use_rd;   // result carries the value store data
    logic [STATUS_BITS-1:0] status;
  } kvt_cmd_t;

  typedef struct packed {
    logic is_get;
    logic hit;
    logic miss;
    logic full;
  } kvt_stat_t;

endpackage

`default_nettype wire

### hdl/kvt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module kvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/kvt_ctrl.sv
// Controller of the key-value table: sequences the scan and the update.
// Depends on kvt_pkg.
`default_nettype none

module kvt_ctrl import kvt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire kvt_stat_t stat,
  output kvt_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_GETRD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = ST_UPDATED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.at_hit = 1'b1;
          if (stat.is_get) begin
            state_next = S_GETRD;
          end else begin
            cmd.wr_val  = 1'b1;
            cmd.respond = 1'b1;
            cmd.status  = ST_UPDATED;
            state_next  = S_IDLE;
          end
        end else if (stat.miss) begin
          cmd.respond = 1'b1;
          state_next  = S_IDLE;
          if (stat.is_get) begin
            cmd.status = ST_NOT_FOUND;
          end else if (stat.full) begin
            cmd.status = ST_DROPPED;
          end else begin
            cmd.wr_key = 1'b1;
            cmd.wr_val = 1'b1;
            cmd.status = ST_INSERTED;
          end
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_GETRD: begin
        cmd.respond = 1'b1;
        cmd.use_rd  = 1'b1;
        cmd.status  = ST_FOUND;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/kvt_dp.sv
// Datapath of the key-value table: request registers, fill count, scan
// pointer, key and value stores and the result registers.
// Depends on kvt_pkg and kvt_ram.
`default_nettype none

module kvt_dp import kvt_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_type,
  input  wire logic [REQ_KEY_BITS-1:0] lookup_key,
  input  wire logic [REQ_VAL_BITS-1:0] put_value,
  input  wire kvt_cmd_t                cmd,
  output kvt_stat_t                    stat,
  output logic                         done,
  output logic [STATUS_BITS-1:0]       status,
  output logic [REQ_VAL_BITS-1:0]      read_value,
  output logic [ENTRY_BITS-1:0]        entry_count
);

  logic                  req_get;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;

  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic [COUNT_W-1:0]    scan_idx;
  logic                  cmp_valid;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  more;

  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [IDX_W-1:0]      val_addr;
  logic [IDX_W-1:0]      fill_addr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_get <= (req_type == REQ_GET);
      req_key <= KEY_BITS'(lookup_key);
      req_val <= VALUE_BITS'(put_value);
    end
  end

  assign more       = (scan_idx < count);
  assign fill_addr  = count[IDX_W-1:0];
  assign val_addr   = cmd.at_hit ? cmp_idx : fill_addr;
  assign count_next = cmd.wr_key ? count + COUNT_W'(1) : count;

  // One key read goes out per cycle; its compare happens the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.load) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= more;
        if (more) begin
          scan_idx <= scan_idx + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
    end
  end

  assign stat.is_get = req_get;
  assign stat.hit    = cmp_valid && (key_rdata == req_key);
  assign stat.miss   = !cmp_valid && !more;
  assign stat.full   = (count == COUNT_W'(TABLE_DEPTH));

  kvt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.wr_key),
    .waddr (fill_addr),
    .wdata (req_key),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (key_rdata)
  );

  kvt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (cmd.wr_val),
    .waddr (val_addr),
    .wdata (req_val),
    .raddr (val_addr),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      status      <= cmd.status;
      read_value  <= cmd.use_rd ? REQ_VAL_BITS'(val_rdata) : '0;
      entry_count <= ENTRY_BITS'(count_next);
    end
  end

endmodule

`default_nettype wire

### hdl/key_value_table_core.sv
// Key-value table with linear search over up to TABLE_DEPTH entries.
// One request at a time: the next is accepted at the edge that ends the done
// cycle. The key store is read one entry per cycle during the scan. Results
// cannot be stalled by the receiver.
// Reset empties the table (count to zero); the stores need no clearing.
`default_nettype none

module key_value_table_core import kvt_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    req_type,
  input  wire logic [REQ_KEY_BITS-1:0] lookup_key,
  input  wire logic [REQ_VAL_BITS-1:0] put_value,
  output logic                         done,
  output logic [STATUS_BITS-1:0]       status,
  output logic [REQ_VAL_BITS-1:0]      read_value,
  output logic [ENTRY_BITS-1:0]        entry_count
);

  kvt_cmd_t  cmd;
  kvt_stat_t stat;

  kvt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  kvt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .lookup_key  (lookup_key),
    .put_value   (put_value),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  // A result word is only produced once the controller has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // An accepted word always occupies the block the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // An insert always leaves at least one entry in the table.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) == 1'b0 && status == ST_INSERTED) |->
      (entry_count != 8'd0 || TABLE_DEPTH > 255))
    else $error("insert left the table empty");

  // A get or a put that does not insert leaves no value on a miss.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NOT_FOUND || status == ST_DROPPED)) |->
      (read_value == '0))
    else $error("miss returned a value");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for key_value_table_core: a short directed table, then
// random put and get requests checked against a table model kept in this file.
// Depends on kvt_pkg (sizes, status and request codes) and the core itself.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [REQ_VAL_BITS-1:0] value;
    logic [ENTRY_BITS-1:0]   count;
  } table_answer_t;

  typedef struct {
    logic                    req;
    logic [REQ_KEY_BITS-1:0] key;
    logic [REQ_VAL_BITS-1:0] val;
    bit                      typed;
    table_answer_t           want;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    req_type = REQ_PUT;
  logic [REQ_KEY_BITS-1:0] lookup_key = '0;
  logic [REQ_VAL_BITS-1:0] put_value = '0;
  logic                    busy;
  logic                    done;
  logic [STATUS_BITS-1:0]  status;
  logic [REQ_VAL_BITS-1:0] read_value;
  logic [ENTRY_BITS-1:0]   entry_count;

  // Model of the table contents, in insertion order.
  logic [KEY_BITS-1:0]   model_keys [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] model_vals [TABLE_DEPTH];
  int                    model_fill = 0;

  table_answer_t pending_answers [$];
  stim_row_t     directed_rows [$];
  int            mismatch_count = 0;
  int            sent_count = 0;
  int            status_seen [8];
  int            cycle_count = 0;
  bit            no_gaps = 1'b0;

  key_value_table_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .lookup_key  (lookup_key),
    .put_value   (put_value),
    .done        (done),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_value_table_core regression: fail");
      $finish;
    end
  end

  // Linear search over the occupied entries; a put then updates or appends (or is dropped when full), a get reads.
  task apply_to_table(input logic req, input logic [REQ_KEY_BITS-1:0] key,
                      input logic [REQ_VAL_BITS-1:0] val, output table_answer_t answer);
    int slot;
    slot = -1;
    for (int i = 0; i < model_fill; i++) begin
      if (slot < 0 && model_keys[i] == key[KEY_BITS-1:0]) slot = i;
    end
    answer.value = '0;
    if (req == REQ_PUT) begin
      if (slot >= 0) begin
        model_vals[slot] = val[VALUE_BITS-1:0];
        answer.status = ST_UPDATED;
      end else if (model_fill < TABLE_DEPTH) begin
        model_keys[model_fill] = key[KEY_BITS-1:0];
        model_vals[model_fill] = val[VALUE_BITS-1:0];
        model_fill++;
        answer.status = ST_INSERTED;
      end else begin
        answer.status = ST_DROPPED;
      end
    end else begin
      if (slot >= 0) begin
        answer.value = REQ_VAL_BITS'(model_vals[slot]);
        answer.status = ST_FOUND;
      end else begin
        answer.status = ST_NOT_FOUND;
      end
    end
    answer.count = ENTRY_BITS'(model_fill);
  endtask

  // Called at a rising edge; returns at the edge where the word was taken,
  // with start still high so a back-to-back word can follow.
  task send_request(input logic req, input logic [REQ_KEY_BITS-1:0] key,
                    input logic [REQ_VAL_BITS-1:0] val, input bit typed,
                    input table_answer_t want);
    int            gap;
    table_answer_t model_answer;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= req;
    lookup_key <= key;
    put_value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_to_table(req, key, val, model_answer);
    pending_answers.push_back(typed ? want : model_answer);
    sent_count++;
  endtask

  task wait_for_drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  always @(posedge clk) begin : answer_check
    table_answer_t want;
    if (!rst && done === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("result word with nothing expected: status %0d", status);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        status_seen[want.status]++;
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatch_count++;
        end
        if (read_value !== want.value) begin
          $error("read_value: expected %h, actual %h", want.value, read_value);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic                    req;
    logic [REQ_KEY_BITS-1:0] key;
    logic [REQ_VAL_BITS-1:0] val;
    int                      pick;
    int                      directed_count;

    foreach (status_seen[i]) status_seen[i] = 0;

    // Rows with an answer typed in are the ones readable by eye; the rest
    // take the model's answer.
    directed_rows.push_back('{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
                              '{ST_NOT_FOUND, 32'h0, 8'd0}});
    directed_rows.push_back('{REQ_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                              '{ST_INSERTED, 32'h0, 8'd1}});
    directed_rows.push_back('{REQ_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                              '{ST_INSERTED, 32'h0, 8'd2}});
    directed_rows.push_back('{REQ_GET, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1,
                              '{ST_FOUND, 32'hFFFF_FFFF, 8'd2}});
    directed_rows.push_back('{REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              '{ST_FOUND, 32'h0000_0000, 8'd2}});
    directed_rows.push_back('{REQ_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1,
                              '{ST_UPDATED, 32'h0, 8'd2}});
    directed_rows.push_back('{REQ_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
                              '{ST_FOUND, 32'h1234_5678, 8'd2}});
    directed_rows.push_back('{REQ_GET, 32'h0000_0001, 32'h0000_0000, 1'b1,
                              '{ST_NOT_FOUND, 32'h0, 8'd2}});
    directed_rows.push_back('{REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
                              '{ST_NOT_FOUND, 32'h0, 8'd2}});
    directed_rows.push_back('{REQ_PUT, 32'h8000_0000, 32'h8000_0000, 1'b1,
                              '{ST_INSERTED, 32'h0, 8'd3}});
    directed_rows.push_back('{REQ_PUT, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1,
                              '{ST_INSERTED, 32'h0, 8'd4}});
    directed_rows.push_back('{REQ_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
                              '{ST_FOUND, 32'h8000_0000, 8'd4}});
    directed_rows.push_back('{REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              '{ST_UPDATED, 32'h0, 8'd4}});
    directed_rows.push_back('{REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                              '{ST_FOUND, 32'hFFFF_FFFF, 8'd4}});
    directed_rows.push_back('{REQ_GET, 32'h0000_0001, 32'h0000_0000, 1'b1,
                              '{ST_FOUND, 32'h7FFF_FFFF, 8'd4}});
    directed_rows.push_back('{REQ_PUT, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 1'b0, '0});
    directed_rows.push_back('{REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0});
    directed_rows.push_back('{REQ_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0, '0});
    directed_rows.push_back('{REQ_GET, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0});
    directed_rows.push_back('{REQ_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].key, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    directed_count = sent_count;

    // Hold the sender off until every answer so far has come back.
    wait_for_drain();

    // Puts lean toward new keys so the table fills up partway through and
    // the rest of the run exercises dropped puts against a full table.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      req  = ($urandom_range(0, 1) == 1) ? REQ_GET : REQ_PUT;
      pick = $urandom_range(0, 99);
      if (model_fill > 0 && pick < ((req == REQ_PUT) ? 35 : 60)) begin
        key = model_keys[$urandom_range(0, model_fill - 1)];
      end else if (model_fill > 0 && pick < ((req == REQ_PUT) ? 45 : 75)) begin
        // Near miss: one bit away from a stored key.
        key = model_keys[$urandom_range(0, model_fill - 1)] ^ (32'h1 << $urandom_range(0, 31));
      end else if (pick >= 97) begin
        key = (pick == 99) ? 32'hFFFF_FFFF : 32'h0000_0000;
      end else begin
        key = $urandom;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) val = 32'h0000_0000;
      else if (pick == 1) val = 32'hFFFF_FFFF;
      else val = $urandom;
      send_request(req, key, val, 1'b0, '0);
    end

    wait_for_drain();
    repeat (TABLE_DEPTH + 10) @(posedge clk);

    $display("Sent %0d requests (%0d directed); table reached %0d of %0d entries.",
             sent_count, directed_count, model_fill, TABLE_DEPTH);
    $display("Answers: %0d updated, %0d inserted, %0d dropped, %0d found, %0d not found.",
             status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_DROPPED],
             status_seen[ST_FOUND], status_seen[ST_NOT_FOUND]);
    if (mismatch_count == 0) begin
      $display("key_value_table_core regression: pass");
    end else begin
      $display("key_value_table_core regression: fail");
    end
    $finish;
  end

endmodule

### key_value_table_core.f
hdl/kvt_pkg.sv
hdl/kvt_ram.sv
hdl/kvt_ctrl.sv
hdl/kvt_dp.sv
hdl/key_value_table_core.sv
sim/tb_top.sv
